// ----- sv/adc_event_word_unpacker_assert.svh -----
// assertion macros shared by the checker of the adc event word unpacker
// no dependencies; included by the files that assert
`ifndef ADC_EVENT_WORD_UNPACKER_ASSERT_SVH
`define ADC_EVENT_WORD_UNPACKER_ASSERT_SVH

// property that must hold on every clock edge out of reset
`define EWU_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// antecedent in one cycle implies the consequent in the next
`define EWU_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/adc_ewu_pkg.sv -----
// types, codes and helpers of the adc event word unpacker
// no dependencies; imported by the top level, parser, readout and checker
`default_nettype none

package adc_ewu_pkg;

  localparam int NUM_CHANNELS_DEF = 32;

  localparam logic [2:0] TYPE_DATA    = 3'd0;
  localparam logic [2:0] TYPE_TRAILER = 3'd4;

  localparam logic [12:0] OVER_VALUE = 13'd4096;

  localparam logic [1:0] ST_TRAILER    = 2'd0;
  localparam logic [1:0] ST_NO_TRAILER = 2'd1;
  localparam logic [1:0] ST_MISMATCH   = 2'd2;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_EVENT,
    PH_AFTER,
    PH_AFTER_LONE
  } phase_t;

  typedef enum logic {
    RO_IDLE,
    RO_SHOW
  } ro_state_t;

  // readout request from the parser to the readout sequencer
  typedef struct packed {
    logic        start;
    logic        use_valid;
    logic [1:0]  status_first;
    logic        second;
    logic [1:0]  status_second;
    logic [31:0] mis_first;
  } ro_req_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

endpackage

`default_nettype wire

// ----- sv/adc_event_word_unpacker.sv -----
// Multichannel ADC event word unpacker, top level.
// Input channel: in_valid / in_ready with one 32-bit readout_word per request.
// Output channel: out_valid / out_ready, one request per channel result with
// event_status, channel_index, channel_value, channel_present, last_of_event
// and the three saturating counters as they stood when the event closed.
// Config channel: cfg_valid / cfg_ready carrying expected_module_address; it is
// always ready and must only be written while the block is idle.
// Words that start no readout, such as data words, are taken back to back. A
// word that closes an event starts a readout of NUM_CHANNELS results at one
// result per cycle while out_ready is high, from the channel ram (registered
// read, issued ahead of each result); a word that closes an event and
// mismatches as a header gives two readouts back to back. in_ready is low
// while a readout is running. The first result shows the cycle after the
// closing word is taken; the next word is taken once the last result of the
// readout, or of both readouts, has been accepted.
// Reset: phase expects a header, counters zero, all channels absent, register
// zero. A stalled receiver holds the current result stable and halts the
// ram walk; no result is dropped.
`default_nettype none

module adc_event_word_unpacker #(
  parameter int NUM_CHANNELS = adc_ewu_pkg::NUM_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [4:0]  expected_module_address,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [31:0] readout_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [1:0]       event_status,
  output logic [4:0]       channel_index,
  output logic [12:0]      channel_value,
  output logic             channel_present,
  output logic             last_of_event,
  output logic [31:0]      data_word_count,
  output logic [31:0]      overflow_count,
  output logic [31:0]      mismatch_count
);

  import adc_ewu_pkg::*;

  localparam int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                    busy, clear_valid, wr_en, rd_en;
  logic [AW-1:0]           wr_addr, rd_addr;
  logic [12:0]             wr_data, rd_data;
  logic [NUM_CHANNELS-1:0] valid_bits;
  logic [31:0]             mis_cnt;
  ro_req_t                 req;

  assign cfg_ready = 1'b1;
  assign in_ready  = ~busy;

  adc_ewu_parser #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .AW(AW)
  ) u_parser (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_valid & cfg_ready),
    .cfg_addr(expected_module_address),
    .in_accept(in_valid & in_ready),
    .readout_word(readout_word),
    .clear_valid(clear_valid),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .valid_bits(valid_bits),
    .req(req),
    .data_cnt(data_word_count),
    .ovf_cnt(overflow_count),
    .mis_cnt(mis_cnt)
  );

  adc_ewu_ram #(
    .WIDTH(13),
    .DEPTH(NUM_CHANNELS),
    .AW(AW)
  ) u_chan_ram (
    .clk(clk),
    .wr_en(wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  adc_ewu_readout #(
    .NUM_CHANNELS(NUM_CHANNELS),
    .AW(AW)
  ) u_readout (
    .clk(clk),
    .rst(rst),
    .req(req),
    .valid_bits(valid_bits),
    .mis_live(mis_cnt),
    .rd_data(rd_data),
    .rd_en(rd_en),
    .rd_addr(rd_addr),
    .busy(busy),
    .clear_valid(clear_valid),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .event_status(event_status),
    .channel_index(channel_index),
    .channel_value(channel_value),
    .channel_present(channel_present),
    .last_of_event(last_of_event),
    .mismatch_count(mismatch_count)
  );

endmodule

`default_nettype wire

// ----- sv/adc_ewu_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module adc_ewu_ram #(
  parameter int WIDTH = 13,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/adc_ewu_parser.sv -----
// word parser: phase machine, counters, channel valid bits, ram write side
// depends on adc_ewu_pkg
`default_nettype none

module adc_ewu_parser #(
  parameter int NUM_CHANNELS = adc_ewu_pkg::NUM_CHANNELS_DEF,
  parameter int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_write,
  input  wire logic [4:0]              cfg_addr,
  input  wire logic                    in_accept,
  input  wire logic [31:0]             readout_word,
  input  wire logic                    clear_valid,
  output logic                         wr_en,
  output logic [AW-1:0]                wr_addr,
  output logic [12:0]                  wr_data,
  output logic [NUM_CHANNELS-1:0]      valid_bits,
  output adc_ewu_pkg::ro_req_t         req,
  output logic [31:0]                  data_cnt,
  output logic [31:0]                  ovf_cnt,
  output logic [31:0]                  mis_cnt
);

  import adc_ewu_pkg::*;

  phase_t      phase, phase_next;
  logic [4:0]  exp_addr;
  logic [31:0] data_cnt_next, ovf_cnt_next, mis_cnt_next;
  logic [2:0]  wtype;
  logic [5:0]  wchan;
  logic        filler, do_hdr, ev_emit, hdr_emit;
  logic [1:0]  ev_status, hdr_status;

  assign wtype  = readout_word[26:24];
  assign wchan  = readout_word[21:16];
  assign filler = &readout_word;

  always_comb begin
    phase_next    = phase;
    data_cnt_next = data_cnt;
    ovf_cnt_next  = ovf_cnt;
    mis_cnt_next  = mis_cnt;
    ev_emit       = 1'b0;
    ev_status     = ST_TRAILER;
    do_hdr        = 1'b0;
    hdr_emit      = 1'b0;
    hdr_status    = ST_TRAILER;
    wr_en         = 1'b0;
    wr_addr       = wchan[AW-1:0];
    wr_data       = readout_word[12] ? OVER_VALUE : {1'b0, readout_word[11:0]};
    if (in_accept) begin
      case (phase)
        PH_EVENT: begin
          if (wtype == TYPE_DATA) begin
            data_cnt_next = sat_inc(data_cnt);
            if (!readout_word[13]) begin
              if (readout_word[12]) begin
                ovf_cnt_next = sat_inc(ovf_cnt);
              end
              wr_en = (wchan < 6'(NUM_CHANNELS));
            end
          end else if (wtype == TYPE_TRAILER) begin
            ev_emit    = 1'b1;
            ev_status  = ST_TRAILER;
            phase_next = PH_AFTER;
          end else begin
            ev_emit   = 1'b1;
            ev_status = ST_NO_TRAILER;
            if (filler) begin
              phase_next = PH_HEADER;
            end else begin
              do_hdr = 1'b1;
            end
          end
        end
        PH_AFTER: begin
          if (wtype != TYPE_TRAILER) begin
            if (filler) begin
              phase_next = PH_HEADER;
            end else begin
              do_hdr = 1'b1;
            end
          end
        end
        PH_AFTER_LONE: begin
          if (filler) begin
            phase_next = PH_HEADER;
          end else begin
            do_hdr = 1'b1;
          end
        end
        default: begin
          do_hdr = 1'b1;
        end
      endcase
    end
    // header handling, possibly in the same word that closed an event
    if (do_hdr) begin
      if (readout_word[31:27] != exp_addr) begin
        mis_cnt_next = sat_inc(mis_cnt);
        phase_next   = PH_HEADER;
        hdr_emit     = 1'b1;
        hdr_status   = ST_MISMATCH;
      end else if (wtype == TYPE_TRAILER) begin
        phase_next = PH_AFTER_LONE;
        hdr_emit   = 1'b1;
        hdr_status = ST_TRAILER;
      end else begin
        phase_next = PH_EVENT;
      end
    end
  end

  always_comb begin
    req.start         = ev_emit | hdr_emit;
    req.use_valid     = ev_emit;
    req.status_first  = ev_emit ? ev_status : hdr_status;
    req.second        = ev_emit & hdr_emit;
    req.status_second = hdr_status;
    req.mis_first     = ev_emit ? mis_cnt : mis_cnt_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_HEADER;
      exp_addr <= 5'd0;
      data_cnt <= 32'd0;
      ovf_cnt  <= 32'd0;
      mis_cnt  <= 32'd0;
    end else begin
      phase    <= phase_next;
      data_cnt <= data_cnt_next;
      ovf_cnt  <= ovf_cnt_next;
      mis_cnt  <= mis_cnt_next;
      if (cfg_write) begin
        exp_addr <= cfg_addr;
      end
    end
  end

  // valid bits are emptied once an event readout has gone out
  always_ff @(posedge clk) begin
    if (rst || clear_valid) begin
      valid_bits <= '0;
    end else if (wr_en) begin
      valid_bits[wr_addr] <= 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- sv/adc_ewu_readout.sv -----
// readout sequencer: walks the channel ram and presents one result per channel
// depends on adc_ewu_pkg
`default_nettype none

module adc_ewu_readout #(
  parameter int NUM_CHANNELS = adc_ewu_pkg::NUM_CHANNELS_DEF,
  parameter int AW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire adc_ewu_pkg::ro_req_t    req,
  input  wire logic [NUM_CHANNELS-1:0] valid_bits,
  input  wire logic [31:0]             mis_live,
  input  wire logic [12:0]             rd_data,
  output logic                         rd_en,
  output logic [AW-1:0]                rd_addr,
  output logic                         busy,
  output logic                         clear_valid,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [1:0]                   event_status,
  output logic [4:0]                   channel_index,
  output logic [12:0]                  channel_value,
  output logic                         channel_present,
  output logic                         last_of_event,
  output logic [31:0]                  mismatch_count
);

  import adc_ewu_pkg::*;

  ro_state_t   state, state_next;
  logic [4:0]  ch, ch_next, ch_inc;
  logic [1:0]  status, status_next, status2, status2_next;
  logic        use_valid, use_valid_next, pend, pend_next;
  logic [31:0] mis, mis_next;
  logic        last;

  assign ch_inc = ch + 5'd1;
  assign last   = (ch == 5'(NUM_CHANNELS - 1));

  always_comb begin
    state_next     = state;
    ch_next        = ch;
    status_next    = status;
    status2_next   = status2;
    use_valid_next = use_valid;
    pend_next      = pend;
    mis_next       = mis;
    rd_en          = 1'b0;
    rd_addr        = '0;
    clear_valid    = 1'b0;
    case (state)
      RO_IDLE: begin
        if (req.start) begin
          state_next     = RO_SHOW;
          ch_next        = 5'd0;
          rd_en          = 1'b1;
          status_next    = req.status_first;
          use_valid_next = req.use_valid;
          pend_next      = req.second;
          status2_next   = req.status_second;
          mis_next       = req.mis_first;
        end
      end
      RO_SHOW: begin
        if (out_ready) begin
          if (!last) begin
            ch_next = ch_inc;
            rd_en   = 1'b1;
            rd_addr = ch_inc[AW-1:0];
          end else begin
            clear_valid = use_valid;
            if (pend) begin
              // header readout that follows an event closed without trailer
              ch_next        = 5'd0;
              rd_en          = 1'b1;
              status_next    = status2;
              use_valid_next = 1'b0;
              pend_next      = 1'b0;
              mis_next       = mis_live;
            end else begin
              state_next = RO_IDLE;
            end
          end
        end
      end
      default: begin
        state_next = RO_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RO_IDLE;
      use_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state     <= state_next;
      use_valid <= use_valid_next;
      pend      <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ch      <= ch_next;
    status  <= status_next;
    status2 <= status2_next;
    mis     <= mis_next;
  end

  assign busy            = (state != RO_IDLE);
  assign out_valid       = (state == RO_SHOW);
  assign event_status    = status;
  assign channel_index   = ch;
  assign channel_present = use_valid & valid_bits[ch[AW-1:0]];
  assign channel_value   = channel_present ? rd_data : 13'd0;
  assign last_of_event   = last;
  assign mismatch_count  = mis;

endmodule

`default_nettype wire

// ----- sv/adc_ewu_checker.sv -----
// port level checker of the adc event word unpacker, bound to the top level
// depends on adc_ewu_pkg and adc_event_word_unpacker_assert.svh
`default_nettype none

module adc_ewu_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  event_status,
  input wire logic [4:0]  channel_index,
  input wire logic [12:0] channel_value,
  input wire logic        channel_present,
  input wire logic        last_of_event
);

  import adc_ewu_pkg::*;

`include "adc_event_word_unpacker_assert.svh"

  logic       stall, moved, mis_data;
  logic [4:0] index_up;

  assign stall    = out_valid && !out_ready;
  assign moved    = out_valid && out_ready && !last_of_event;
  assign mis_data = out_valid && (event_status == ST_MISMATCH) && channel_present;
  assign index_up = channel_index + 5'd1;

  // a stalled result keeps its channel
  `EWU_ASSERT_NEXT(a_hold, clk, rst, stall, out_valid && $stable(channel_index), "stall not held")

  // no new word is taken while a readout is running
  `EWU_ASSERT(a_excl, clk, rst, !(in_ready && out_valid), "input taken during readout")

  // an absent channel reads zero
  `EWU_ASSERT(a_absent, clk, rst, channel_present || channel_value == 13'd0, "absent not zero")

  // a mismatch readout never carries channel data
  `EWU_ASSERT(a_mis, clk, rst, !mis_data, "data in mismatch readout")

  // channels walk up by one inside a readout
  `EWU_ASSERT_NEXT(a_walk, clk, rst, moved, channel_index == $past(index_up), "order broken")

endmodule

bind adc_event_word_unpacker adc_ewu_checker u_checker (
  .clk(clk),
  .rst(rst),
  .in_ready(in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .event_status(event_status),
  .channel_index(channel_index),
  .channel_value(channel_value),
  .channel_present(channel_present),
  .last_of_event(last_of_event)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench for adc_event_word_unpacker: readout words in, per-channel event results out
// checks each result against a predictor or typed row; depends on adc_ewu_pkg and the rtl
`timescale 1ns / 1ps

module tb_top;
  import adc_ewu_pkg::*;

  localparam int          NUM_CHANS   = NUM_CHANNELS_DEF;
  localparam logic [31:0] FILLER      = 32'hFFFF_FFFF;
  localparam int          SETTLE      = 40;
  localparam int          CYCLE_LIMIT = 600000;
  localparam int          PHASE_WORDS = 45;

  // one channel result as the block reports it
  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  chan;
    logic [12:0] value;
    logic        present;
    logic        last;
    logic [31:0] dw;
    logic [31:0] ov;
    logic [31:0] mis;
  } chan_result_t;

  // readout written out by hand: every channel absent, counters as given
  typedef struct packed {
    logic        on;
    logic [1:0]  status;
    logic [31:0] dw;
    logic [31:0] ov;
    logic [31:0] mis;
  } typed_readout_t;

  typedef struct packed {
    logic [31:0]    word;
    typed_readout_t typed;
  } directed_row_t;

  localparam typed_readout_t NO_TYPED = '{1'b0, ST_TRAILER, 32'd0, 32'd0, 32'd0};

  localparam directed_row_t DIRECTED [26] = '{
    '{32'h0800_0000, '{1'b1, ST_MISMATCH, 32'd0, 32'd0, 32'd1}}, // wrong address
    '{32'hFFFF_FFFF, '{1'b1, ST_MISMATCH, 32'd0, 32'd0, 32'd2}}, // all-ones as header
    '{32'h0400_0000, '{1'b1, ST_TRAILER, 32'd0, 32'd0, 32'd2}},  // lone trailer header
    '{32'hFFFF_FFFF, NO_TYPED},  // filler after lone trailer
    '{32'h0000_0000, NO_TYPED},  // header opens event
    '{32'h0000_0FFF, NO_TYPED},  // channel 0, largest value
    '{32'h001F_1ABC, NO_TYPED},  // channel 31 overflow
    '{32'h0001_2345, NO_TYPED},  // underflow, counted only
    '{32'h0002_3ABC, NO_TYPED},  // underflow and overflow together
    '{32'h003F_0123, NO_TYPED},  // channel 63, out of range
    '{32'h0028_1000, NO_TYPED},  // out of range overflow still counted
    '{32'hF8C5_C555, NO_TYPED},  // data with address and spare bits set
    '{32'h0400_0000, NO_TYPED},  // trailer closes event
    '{32'h04AB_CDEF, NO_TYPED},  // repeated trailer absorbed
    '{32'hFFFF_FFFF, NO_TYPED},  // filler absorbed
    '{32'h0300_0000, NO_TYPED},  // header of odd type still opens
    '{32'h0003_0001, NO_TYPED},
    '{32'h0200_0000, NO_TYPED},  // closes without trailer and reopens
    '{32'h0004_0042, NO_TYPED},
    '{32'h0900_0000, NO_TYPED},  // closes, then mismatches: two readouts
    '{32'h0000_0000, NO_TYPED},
    '{32'hFFFF_FFFF, NO_TYPED},  // closes without trailer, taken as filler
    '{32'h0400_0000, NO_TYPED},  // lone trailer header
    '{32'h0000_0000, NO_TYPED},  // non-filler after lone trailer is a header
    '{32'h0400_0000, NO_TYPED},  // empty event closed by trailer
    '{32'h0800_0000, NO_TYPED}   // mismatched header after trailer
  };

  logic        clk;
  logic        rst;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [4:0]  expected_module_address;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] readout_word;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  event_status;
  logic [4:0]  channel_index;
  logic [12:0] channel_value;
  logic        channel_present;
  logic        last_of_event;
  logic [31:0] data_word_count;
  logic [31:0] overflow_count;
  logic [31:0] mismatch_count;

  typed_readout_t word_tag;
  logic           idling_on;
  int             stall_left;
  int             words_sent;
  int             err_count;
  int             cycle_count;

  // predictor state
  phase_t                parse_ph    = PH_HEADER;
  logic [4:0]            match_addr  = 5'd0;
  logic [12:0]           stored_val [NUM_CHANS];
  logic [NUM_CHANS-1:0]  chan_hit    = '0;
  logic [31:0]           words_seen  = '0;
  logic [31:0]           ovf_seen    = '0;
  logic [31:0]           mis_seen    = '0;
  chan_result_t          step_out [$];
  chan_result_t          readout_fifo [$];

  adc_event_word_unpacker #(.NUM_CHANNELS(NUM_CHANS)) DUT (
    .clk                     (clk),
    .rst                     (rst),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .expected_module_address (expected_module_address),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .readout_word            (readout_word),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .event_status            (event_status),
    .channel_index           (channel_index),
    .channel_value           (channel_value),
    .channel_present         (channel_present),
    .last_of_event           (last_of_event),
    .data_word_count         (data_word_count),
    .overflow_count          (overflow_count),
    .mismatch_count          (mismatch_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void emit_readout(input logic [1:0] status);
    chan_result_t r;
    for (int ch = 0; ch < NUM_CHANS; ch++) begin
      r.status  = status;
      r.chan    = 5'(ch);
      r.value   = chan_hit[ch] ? stored_val[ch] : 13'd0;
      r.present = chan_hit[ch];
      r.last    = (ch == NUM_CHANS - 1);
      r.dw      = words_seen;
      r.ov      = ovf_seen;
      r.mis     = mis_seen;
      step_out.push_back(r);
    end
  endfunction

  function automatic void take_header(input logic [31:0] w);
    chan_hit = '0;
    if (w[31:27] != match_addr) begin
      if (mis_seen != '1) mis_seen = mis_seen + 1;
      parse_ph = PH_HEADER;
      emit_readout(ST_MISMATCH);
    end else if (w[26:24] == TYPE_TRAILER) begin
      parse_ph = PH_AFTER_LONE;
      emit_readout(ST_TRAILER);
    end else begin
      parse_ph = PH_EVENT;
    end
  endfunction

  function automatic void unpack_word(input logic [31:0] w);
    logic [12:0] v;
    int          idx;
    idx = int'(w[21:16]);
    case (parse_ph)
      PH_EVENT: begin
        if (w[26:24] == TYPE_DATA) begin
          if (words_seen != '1) words_seen = words_seen + 1;
          if (!w[13]) begin
            v = {1'b0, w[11:0]};
            if (w[12]) begin
              if (ovf_seen != '1) ovf_seen = ovf_seen + 1;
              v = OVER_VALUE;
            end
            if (idx < NUM_CHANS) begin
              stored_val[idx] = v;
              chan_hit[idx]   = 1'b1;
            end
          end
        end else if (w[26:24] == TYPE_TRAILER) begin
          emit_readout(ST_TRAILER);
          parse_ph = PH_AFTER;
        end else begin
          emit_readout(ST_NO_TRAILER);
          if (w == FILLER) parse_ph = PH_HEADER;
          else take_header(w);
        end
      end
      PH_AFTER: begin
        if (w[26:24] != TYPE_TRAILER) begin
          if (w == FILLER) parse_ph = PH_HEADER;
          else take_header(w);
        end
      end
      PH_AFTER_LONE: begin
        if (w == FILLER) parse_ph = PH_HEADER;
        else take_header(w);
      end
      default: take_header(w);
    endcase
  endfunction

  task automatic flag_field(input string field, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      err_count++;
    end
  endtask

  // predict on each accepted word, then check each accepted result
  always @(posedge clk) begin
    chan_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        step_out.delete();
        unpack_word(readout_word);
        if (word_tag.on) begin
          for (int ch = 0; ch < NUM_CHANS; ch++)
            readout_fifo.push_back(chan_result_t'{word_tag.status, 5'(ch), 13'd0, 1'b0,
                                                  ch == NUM_CHANS - 1, word_tag.dw,
                                                  word_tag.ov, word_tag.mis});
        end else begin
          foreach (step_out[i]) readout_fifo.push_back(step_out[i]);
        end
      end
      if (cfg_valid && cfg_ready) match_addr = expected_module_address;
      if (out_valid && out_ready) begin
        if (readout_fifo.size() == 0) begin
          $error("result with nothing expected: channel_index %0d", channel_index);
          err_count++;
        end else begin
          want = readout_fifo.pop_front();
          flag_field("event_status", want.status, event_status);
          flag_field("channel_index", want.chan, channel_index);
          flag_field("channel_value", want.value, channel_value);
          flag_field("channel_present", want.present, channel_present);
          flag_field("last_of_event", want.last, last_of_event);
          flag_field("data_word_count", want.dw, data_word_count);
          flag_field("overflow_count", want.ov, overflow_count);
          flag_field("mismatch_count", want.mis, mismatch_count);
        end
      end
    end
  end

  // receiver stalls in bursts of random length
  always @(posedge clk) begin
    if (stall_left > 0) stall_left = stall_left - 1;
    else if (idling_on && $urandom_range(0, 9) == 0) stall_left = $urandom_range(1, 7);
    out_ready <= (stall_left == 0);
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_top: errors");
    $finish;
  end

  task automatic put_word(input logic [31:0] w, input typed_readout_t t);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    readout_word <= w;
    word_tag     <= t;
    do @(posedge clk); while (!in_ready);
    if (w != FILLER) words_sent++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (readout_fifo.size() != 0);
    // a trailing data word gives no result, so let the parser settle
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_module_addr(input logic [4:0] a);
    cfg_valid               <= 1'b1;
    expected_module_address <= a;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // mostly well-formed events with random content, the rest noise
  task automatic send_event();
    int          pick;
    logic [2:0]  ty;
    logic [31:0] w;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      ty = 3'($urandom_range(0, 6));
      if (ty >= TYPE_TRAILER) ty = ty + 3'd1;
      w = $urandom;
      w[31:27] = match_addr;
      w[26:24] = ty;
      if ($urandom_range(0, 19) == 0) w = FILLER;
      put_word(w, NO_TYPED);
      repeat ($urandom_range(0, 8)) begin
        w = $urandom;
        w[26:24] = TYPE_DATA;
        w[21:16] = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(32, 63))
                                                : 6'($urandom_range(0, NUM_CHANS - 1));
        w[13] = ($urandom_range(0, 7) == 0);
        w[12] = ($urandom_range(0, 5) == 0);
        put_word(w, NO_TYPED);
      end
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        repeat ($urandom_range(1, 3)) begin
          w = $urandom;
          w[26:24] = TYPE_TRAILER;
          put_word(w, NO_TYPED);
        end
        if ($urandom_range(0, 1) == 1) put_word(FILLER, NO_TYPED);
      end else if (pick < 9) begin
        w = $urandom;
        if (w[26:24] == TYPE_DATA || w[26:24] == TYPE_TRAILER) w[26:24] = 3'd1;
        if ($urandom_range(0, 1) == 1) w[31:27] = match_addr;
        put_word(w, NO_TYPED);
      end else begin
        put_word(FILLER, NO_TYPED);
      end
    end else if (pick < 80) begin
      w = $urandom;
      w[31:27] = match_addr;
      w[26:24] = TYPE_TRAILER;
      put_word(w, NO_TYPED);
      if ($urandom_range(0, 1) == 1) put_word(FILLER, NO_TYPED);
    end else if (pick < 90) begin
      w = $urandom;
      w[31:27] = match_addr ^ 5'($urandom_range(1, 31));
      put_word(w, NO_TYPED);
    end else begin
      put_word($urandom, NO_TYPED);
    end
  endtask

  initial begin
    int target;
    rst                     <= 1'b1;
    in_valid                <= 1'b0;
    readout_word            <= '0;
    word_tag                <= NO_TYPED;
    cfg_valid               <= 1'b0;
    expected_module_address <= '0;
    out_ready               <= 1'b0;
    idling_on               <= 1'b1;
    stall_left = 0;
    words_sent = 0;
    err_count  = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    write_module_addr(5'd0);
    foreach (DIRECTED[i]) put_word(DIRECTED[i].word, DIRECTED[i].typed);
    for (int p = 0; p < 4; p++) begin
      // hold the sender until every request has drained before reprogramming
      wait_drained();
      if (p == 3) idling_on <= 1'b0;
      if (p == 0) write_module_addr(5'd31);
      else if (p == 2) write_module_addr(5'd0);
      else write_module_addr(5'($urandom_range(0, 31)));
      target = words_sent + PHASE_WORDS;
      while (words_sent < target) send_event();
    end
    wait_drained();
    if (readout_fifo.size() != 0) err_count++;
    if (err_count == 0) $display("tb_top: clean");
    else $display("tb_top: errors");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+sv
sv/adc_ewu_pkg.sv
sv/adc_ewu_ram.sv
sv/adc_ewu_parser.sv
sv/adc_ewu_readout.sv
sv/adc_event_word_unpacker.sv
sv/adc_ewu_checker.sv
tb/tb_top.sv
